// ===== hdl/lnc_pkg.sv =====
`timescale 1ns / 1ps

package lnc_pkg;

    localparam int MAX_LENGTH = 64;
    localparam int LEN_W      = 7;
    localparam int PRE_W      = 14;

    localparam logic [LEN_W-1:0] LEN_RELOAD = LEN_W'(MAX_LENGTH);

    typedef enum logic [1:0] {
        MODE_TICK    = 2'd0,
        MODE_LEN_CLK = 2'd1,
        MODE_ENV_CLK = 2'd2,
        MODE_WRITE   = 2'd3
    } lnc_mode_t;

    typedef enum logic [1:0] {
        REG_LENGTH  = 2'd0,
        REG_ENVELOPE = 2'd1,
        REG_POLY    = 2'd2,
        REG_CONTROL = 2'd3
    } lnc_reg_t;

    typedef struct packed {
        lnc_mode_t  mode;
        lnc_reg_t   reg_select;
        logic [7:0] write_data;
        logic       length_phase_odd;
    } lnc_item_t;

    typedef struct packed {
        logic signed [7:0] sample;
        logic              active;
    } lnc_result_t;

    typedef struct packed {
        logic              power_enable;
        logic [15:0]       noise_shift;
        logic [LEN_W-1:0]  length_left;
        logic              length_enable;
        logic              playing;
        logic              dac_on;
        logic [3:0]        cur_volume;
        logic [3:0]        start_volume;
        logic              env_up;
        logic [2:0]        env_period;
        logic [2:0]        env_count;
        logic              env_running;
        logic [3:0]        prescale_shift;
        logic              short_mode;
        logic [2:0]        divide_ratio;
        logic [2:0]        divide_count;
        logic [PRE_W-1:0]  prescale_count;
        logic              skip_tick;
        logic signed [7:0] last_sample;
    } lnc_state_t;

    // Shift left one place; the feedback bit enters at bit 0. In short mode
    // bit 15 mirrors bit 7 so the output tap follows the 7-bit sequence.
    function automatic logic [15:0] lfsr_step(input logic [15:0] s, input logic short_m);
        logic [15:0] r;
        r = {s[14:0], 1'b0};
        if (short_m) begin
            r[0]  = r[6] ^ r[7];
            r[15] = r[7];
        end else begin
            r[0] = r[14] ^ r[15];
        end
        return r;
    endfunction

    function automatic logic [PRE_W-1:0] prescale_reload(input logic [3:0] shift);
        return PRE_W'(32'd1 << shift);
    endfunction

    // +7 or -8 times the volume; both fit in eight signed bits.
    function automatic logic signed [7:0] noise_sample(input logic high, input logic [3:0] vol);
        logic [7:0] v;
        v = {4'b0000, vol};
        if (high) begin
            return (v << 3) - v;
        end else begin
            return 8'd0 - (v << 3);
        end
    endfunction

endpackage

// ===== hdl/lnc_core.sv =====
`timescale 1ns / 1ps

module lnc_core import lnc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        item_fire,
    input  lnc_item_t   item,
    output lnc_result_t result
);

    lnc_state_t state_reg;
    lnc_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg              <= '0;
            state_reg.power_enable <= 1'b1;
            state_reg.noise_shift  <= 16'hffff;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        lnc_state_t n;
        logic [5:0] len_field;
        logic       was_enabled;
        logic       trig;
        logic       vol_ok;
        n           = state_reg;
        len_field   = item.write_data[5:0];
        was_enabled = state_reg.length_enable;
        trig        = item.write_data[7];
        vol_ok      = state_reg.env_up ? (state_reg.cur_volume != 4'hf)
                                       : (state_reg.cur_volume != 4'h0);

        priority if (cfg_wr_en) begin
            // Power off stops the channel and clears the written settings, not the length.
            if (state_reg.power_enable && !cfg_wr_data) begin
                n.playing        = 1'b0;
                n.dac_on         = 1'b0;
                n.start_volume   = '0;
                n.env_up         = 1'b0;
                n.env_period     = '0;
                n.prescale_shift = '0;
                n.short_mode     = 1'b0;
                n.divide_ratio   = '0;
                n.length_enable  = 1'b0;
            end
            n.power_enable = cfg_wr_data;
        end else if (item_fire) begin
            priority if (item.mode == MODE_WRITE && item.reg_select == REG_LENGTH) begin
                if (32'(len_field) < MAX_LENGTH) begin
                    n.length_left = LEN_W'(MAX_LENGTH - 32'(len_field));
                end else begin
                    n.length_left = '0;
                end
            end else if (state_reg.power_enable) begin
                unique case (item.mode)
                    MODE_TICK: begin
                        priority if (state_reg.skip_tick) begin
                            n.skip_tick = 1'b0;
                        end else if (!state_reg.playing) begin
                            n.last_sample = '0;
                        end else if (state_reg.divide_count == '0) begin
                            n.divide_count = state_reg.divide_ratio;
                            if (state_reg.prescale_count == '0) begin
                                n.noise_shift = lfsr_step(state_reg.noise_shift,
                                                          state_reg.short_mode);
                                n.last_sample = state_reg.dac_on ?
                                    noise_sample(n.noise_shift[15], state_reg.cur_volume) :
                                    8'sd0;
                                n.prescale_count = prescale_reload(state_reg.prescale_shift);
                            end else begin
                                n.prescale_count = state_reg.prescale_count - 1'b1;
                            end
                        end else begin
                            n.divide_count = state_reg.divide_count - 1'b1;
                        end
                    end
                    MODE_LEN_CLK: begin
                        if (state_reg.length_enable && state_reg.length_left != '0) begin
                            n.length_left = state_reg.length_left - 1'b1;
                            if (n.length_left == '0 && state_reg.playing) begin
                                n.playing     = 1'b0;
                                n.last_sample = '0;
                                n.env_running = 1'b0;
                            end
                        end
                    end
                    MODE_ENV_CLK: begin
                        if (state_reg.playing && state_reg.env_running) begin
                            priority if (state_reg.env_count != '0) begin
                                n.env_count = state_reg.env_count - 1'b1;
                            end else if (vol_ok) begin
                                n.cur_volume = state_reg.env_up ? state_reg.cur_volume + 1'b1
                                                                : state_reg.cur_volume - 1'b1;
                                n.env_count  = state_reg.env_period;
                            end else begin
                                n.env_running = 1'b0;
                            end
                        end
                    end
                    MODE_WRITE: begin
                        unique case (item.reg_select)
                            REG_LENGTH: begin
                                // Handled ahead of the power check.
                            end
                            REG_ENVELOPE: begin
                                n.start_volume = item.write_data[7:4];
                                n.env_up       = item.write_data[3];
                                n.env_period   = item.write_data[2:0];
                                if (item.write_data[7:3] == 5'd0) begin
                                    n.playing = 1'b0;
                                    n.dac_on  = 1'b0;
                                end else begin
                                    n.dac_on = 1'b1;
                                end
                            end
                            REG_POLY: begin
                                n.prescale_shift = item.write_data[7:4];
                                n.short_mode     = item.write_data[3];
                                n.divide_ratio   = item.write_data[2:0];
                            end
                            REG_CONTROL: begin
                                n.length_enable = item.write_data[6];
                                // Enabling the length counter in an odd phase clocks it once.
                                if (!was_enabled && n.length_enable && item.length_phase_odd
                                    && n.length_left != '0) begin
                                    n.length_left = n.length_left - 1'b1;
                                    if (!trig && n.length_left == '0) begin
                                        n.playing = 1'b0;
                                    end
                                end
                                if (trig) begin
                                    if (n.length_left == '0) begin
                                        n.length_left = LEN_RELOAD;
                                        if (n.length_enable && item.length_phase_odd
                                            && n.length_left != '0) begin
                                            n.length_left = n.length_left - 1'b1;
                                        end
                                    end
                                    if (n.dac_on) begin
                                        n.playing = 1'b1;
                                    end
                                    n.cur_volume  = n.start_volume;
                                    n.env_count   = n.env_period;
                                    n.env_running = n.env_period != '0;
                                    n.skip_tick   = 1'b1;
                                    if (n.playing) begin
                                        n.divide_count   = n.divide_ratio;
                                        n.prescale_count = prescale_reload(n.prescale_shift);
                                    end
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                    default: begin
                    end
                endcase
            end
        end
        state_next = n;
    end

    assign result.sample = state_next.last_sample;
    assign result.active = state_next.playing;

endmodule

// ===== hdl/lfsr_noise_channel.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Payload
// s_        in         s_valid / s_ready    s_mode, s_reg_select, s_write_data,
//                                           s_length_phase_odd
// m_        out        m_valid / m_ready    m_sample_out, m_channel_active
// cfg_      in         cfg_wr_en            cfg_wr_data (power enable)
//
// One word is accepted per cycle unless a result is stalled; the input and
// result registers lie around the single update pass.
// Reset (aresetn low, synchronous) empties both registers and loads the channel
// state, with power enabled and the shift register all ones.
// A stalled result holds the result register; the input register still takes
// one more word, after which s_ready drops until m_ready returns.

module lfsr_noise_channel import lnc_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic              cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_mode,
    input  logic [1:0]        s_reg_select,
    input  logic [7:0]        s_write_data,
    input  logic              s_length_phase_odd,
    output logic              m_valid,
    input  logic              m_ready,
    output logic signed [7:0] m_sample_out,
    output logic              m_channel_active
);

    logic        in_valid_reg;
    logic        in_valid_next;
    lnc_item_t   in_item_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    lnc_result_t out_result_reg;
    lnc_result_t core_result;
    logic        advance;
    logic        item_fire;
    logic        s_fire;

    assign advance   = !out_valid_reg || m_ready;
    assign item_fire = in_valid_reg && advance;
    assign s_ready   = !in_valid_reg || advance;
    assign s_fire    = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (item_fire) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (item_fire) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_item_reg.mode             <= lnc_mode_t'(s_mode);
            in_item_reg.reg_select       <= lnc_reg_t'(s_reg_select);
            in_item_reg.write_data       <= s_write_data;
            in_item_reg.length_phase_odd <= s_length_phase_odd;
        end
        if (item_fire) begin
            out_result_reg <= core_result;
        end
    end

    lnc_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item_fire   (item_fire),
        .item        (in_item_reg),
        .result      (core_result)
    );

    assign m_valid          = out_valid_reg;
    assign m_sample_out     = out_result_reg.sample;
    assign m_channel_active = out_result_reg.active;

endmodule

// ===== hdl/lnc_checker.sv =====
`timescale 1ns / 1ps

module lnc_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input logic signed [7:0] m_sample_out,
    input logic              m_channel_active
);

    // A stalled result word holds still.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_sample_out)
                                && $stable(m_channel_active))
        else $error("result word changed while stalled");

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // Input only stalls when a finished result is waiting downstream.
    a_ready_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without downstream backpressure");

    a_sample_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_sample_out >= -8'sd120 && m_sample_out <= 8'sd105)
        else $error("sample out of range");

    // A negative sample is -8 times the volume.
    a_neg_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_sample_out[7] |-> m_sample_out[2:0] == 3'd0)
        else $error("negative sample not a multiple of eight");

endmodule

bind lfsr_noise_channel lnc_checker u_lnc_checker (.*);
